// ===== sv/hcb_pkg.sv =====
// ============================================================================
// Huffman code builder package
// Shared widths, action and status codes, and controller/datapath bundles.
// ============================================================================
package hcb_pkg;

    localparam int SYMBOLS_DEF      = 256;
    localparam int COUNT_BITS_DEF   = 32;
    localparam int MAX_CODE_LEN_DEF = 48;

    localparam int ACTION_W = 2;
    localparam int SAMPLE_W = 8;
    localparam int CODE_W   = 48;
    localparam int LEN_W    = 6;
    localparam int NSYM_W   = 9;
    localparam int STATUS_W = 2;

    localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_BUILD  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ENCODE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_LONG   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNSEEN = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic cnt_rd;
        logic cnt_wr;
        logic enc_rd;
        logic enc_out;
        logic hist;
        logic scan_init;
        logic scan;
        logic mrg_a;
        logic mrg_b;
        logic mrg_n;
        logic leaf_rd;
        logic step;
        logic fin;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hist_done;
        logic n_zero;
        logic scan_done;
        logic merges_done;
        logic step_cond;
        logic leaf_last;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/hcb_in_if.sv =====
// ============================================================================
// Input channel
// Valid/ready channel carrying one action and one sample per transfer.
// ============================================================================
interface hcb_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcb_pkg::ACTION_W-1:0]  action;
    logic [hcb_pkg::SAMPLE_W-1:0]  sample;

    modport source (output valid, action, sample, input ready);
    modport sink   (input valid, action, sample, output ready);
endinterface

// ===== sv/hcb_out_if.sv =====
// ============================================================================
// Result channel
// Valid/ready channel carrying one code result or build report per transfer.
// ============================================================================
interface hcb_out_if;
    logic                          valid;
    logic                          ready;
    logic [hcb_pkg::CODE_W-1:0]    code_bits;
    logic [hcb_pkg::LEN_W-1:0]     code_length;
    logic [hcb_pkg::NSYM_W-1:0]    symbol_count;
    logic [hcb_pkg::STATUS_W-1:0]  status;

    modport source (output valid, code_bits, code_length, symbol_count, status, input ready);
    modport sink   (input valid, code_bits, code_length, symbol_count, status, output ready);
endinterface

// ===== sv/huffman_code_builder_encoder.sv =====
// ============================================================================
// Huffman code builder and encoder
// Histograms byte samples, builds a Huffman code on request, encodes samples.
// ============================================================================
//
//  Channel  Dir  Payload                                          Transfer when
//  -------  ---  -----------------------------------------------  ----------------
//  i_in     in   action, sample                                   valid & ready
//  o_out    out  code_bits, code_length, symbol_count, status     valid & ready
//
//  One item is in work at a time; i_in.ready is high only while the controller
//  is idle. A count item is accepted, reads its histogram bin, then writes it
//  back. An encode item is accepted, reads the code tables, then waits for
//  the result register to be free. A build item gathers the histogram into
//  leaf nodes, then for each of the n-1 merges makes one pass over the nodes
//  made so far and writes both children and their parent, then walks each of
//  the n leaves up to the root.
//  Reset is synchronous and needs no clearing pass: histogram bins carry valid
//  bits, and reset clears those and the seen flags at once.
//  A stalled result register holds the controller in its final state of the
//  item, so no result is ever dropped or overtaken.
//
module huffman_code_builder_encoder #(
    parameter int SYMBOLS      = hcb_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS   = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hcb_in_if.sink      i_in,
    hcb_out_if.source   o_out
);

    // Commands go down to the datapath, status comes back up.
    hcb_pkg::t_cmd  w_cmd;
    hcb_pkg::t_stat w_stat;

    // The controller owns the input handshake.
    hcb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_action (i_in.action),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready)
    );

    // The datapath holds every memory and the result register.
    hcb_datapath #(
        .SYMBOLS      (SYMBOLS),
        .COUNT_BITS   (COUNT_BITS),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_sample       (i_in.sample),
        .i_out_ready    (o_out.ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_out.valid),
        .o_code_bits    (o_out.code_bits),
        .o_code_length  (o_out.code_length),
        .o_symbol_count (o_out.symbol_count),
        .o_status       (o_out.status)
    );

    // A build report never says a symbol is unseen.
    a_build_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.symbol_count != '0) |-> o_out.status != hcb_pkg::ST_UNSEEN)
        else $error("build report carries unseen status");

    // An empty histogram reports no symbols.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.status == hcb_pkg::ST_EMPTY) |-> o_out.symbol_count == '0)
        else $error("empty build reports symbols");

    // No delivered code is longer than the configured limit.
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> int'(o_out.code_length) <= MAX_CODE_LEN)
        else $error("code length above limit");

    // A result never appears while the controller is ready for new work
    // unless it was already waiting in the register.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready && !o_out.valid |=> !o_out.valid)
        else $error("result without work");

endmodule

// ===== sv/hcb_ctrl.sv =====
// ============================================================================
// Huffman code builder controller
// Sequences counting, encoding and the histogram, merge and walk phases.
// ============================================================================
module hcb_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [hcb_pkg::ACTION_W-1:0]  i_in_action,
    input  hcb_pkg::t_stat                i_stat,
    output hcb_pkg::t_cmd                 o_cmd,
    output logic                          o_in_ready
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_CNT_RD    = 4'd1;
    localparam logic [3:0] S_CNT_WR    = 4'd2;
    localparam logic [3:0] S_ENC_RD    = 4'd3;
    localparam logic [3:0] S_ENC_OUT   = 4'd4;
    localparam logic [3:0] S_HIST      = 4'd5;
    localparam logic [3:0] S_SCAN_INIT = 4'd6;
    localparam logic [3:0] S_SCAN      = 4'd7;
    localparam logic [3:0] S_MRG_A     = 4'd8;
    localparam logic [3:0] S_MRG_B     = 4'd9;
    localparam logic [3:0] S_MRG_N     = 4'd10;
    localparam logic [3:0] S_LEAF_RD   = 4'd11;
    localparam logic [3:0] S_STEP      = 4'd12;
    localparam logic [3:0] S_FIN       = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (i_in_action)
                        hcb_pkg::ACT_COUNT:  n_state = S_CNT_RD;
                        hcb_pkg::ACT_BUILD:  n_state = S_HIST;
                        hcb_pkg::ACT_ENCODE: n_state = S_ENC_RD;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_CNT_RD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state      = S_CNT_WR;
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr = 1'b1;
                n_state      = S_IDLE;
            end
            S_ENC_RD: begin
                o_cmd.enc_rd = 1'b1;
                n_state      = S_ENC_OUT;
            end
            S_ENC_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.enc_out = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_HIST: begin
                o_cmd.hist = 1'b1;
                if (i_stat.hist_done) begin
                    n_state = i_stat.n_zero ? S_FIN : S_SCAN_INIT;
                end
            end
            S_SCAN_INIT: begin
                o_cmd.scan_init = 1'b1;
                n_state = i_stat.merges_done ? S_LEAF_RD : S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_stat.scan_done) begin
                    n_state = S_MRG_A;
                end
            end
            S_MRG_A: begin
                o_cmd.mrg_a = 1'b1;
                n_state     = S_MRG_B;
            end
            S_MRG_B: begin
                o_cmd.mrg_b = 1'b1;
                n_state     = S_MRG_N;
            end
            S_MRG_N: begin
                o_cmd.mrg_n = 1'b1;
                n_state     = S_SCAN_INIT;
            end
            S_LEAF_RD: begin
                o_cmd.leaf_rd = 1'b1;
                n_state       = S_STEP;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (!i_stat.step_cond) begin
                    n_state = i_stat.leaf_last ? S_FIN : S_LEAF_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ===== sv/hcb_datapath.sv =====
// ============================================================================
// Huffman code builder datapath
// Histogram, tree node store, code tables and the result register.
// ============================================================================
module hcb_datapath #(
    parameter int SYMBOLS      = hcb_pkg::SYMBOLS_DEF,
    parameter int COUNT_BITS   = hcb_pkg::COUNT_BITS_DEF,
    parameter int MAX_CODE_LEN = hcb_pkg::MAX_CODE_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hcb_pkg::t_cmd                 i_cmd,
    input  logic [hcb_pkg::SAMPLE_W-1:0]  i_sample,
    input  logic                          i_out_ready,
    output hcb_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [hcb_pkg::CODE_W-1:0]    o_code_bits,
    output logic [hcb_pkg::LEN_W-1:0]     o_code_length,
    output logic [hcb_pkg::NSYM_W-1:0]    o_symbol_count,
    output logic [hcb_pkg::STATUS_W-1:0]  o_status
);

    localparam int SYM_W    = $clog2(SYMBOLS);
    localparam int CNT_W    = SYM_W + 1;
    localparam int NODE_MAX = 2 * SYMBOLS - 1;
    localparam int NODE_W   = $clog2(NODE_MAX);
    localparam int CW       = NODE_W + 1;
    localparam int CODE_W   = hcb_pkg::CODE_W;
    localparam int LEN_W    = hcb_pkg::LEN_W;

    typedef logic [COUNT_BITS-1:0] t_weight;

    typedef struct packed {
        logic [COUNT_BITS-1:0] weight;
        logic [NODE_W-1:0]     parent;
        logic                  bit_one;
        logic                  active;
        logic [SYM_W-1:0]      sym;
    } t_node;

    // Tree order: ascending weight; among equal weights, merged nodes newest
    // first, then leaves in ascending symbol order.
    function automatic logic f_less(t_weight wx, logic [NODE_W-1:0] ix,
                                    t_weight wy, logic [NODE_W-1:0] iy,
                                    logic [NODE_W-1:0] nn);
        logic [NODE_W:0] rx;
        logic [NODE_W:0] ry;
        rx = (ix >= nn) ? {1'b0, ~ix} : {1'b1, ix};
        ry = (iy >= nn) ? {1'b0, ~iy} : {1'b1, iy};
        return (wx < wy) || ((wx == wy) && (rx < ry));
    endfunction

    // Input sample
    logic [hcb_pkg::SAMPLE_W-1:0] r_sample;
    logic                         w_smp_ok;
    logic [SYM_W-1:0]             w_smp_idx;

    // Histogram
    t_weight          r_cnt_mem [SYMBOLS];
    logic             r_cnt_vld [SYMBOLS];
    t_weight          r_cnt_q;
    logic             r_cnt_rv;
    t_weight          w_cnt_eff;
    t_weight          w_cnt_inc;
    logic             w_cnt_re;
    logic [SYM_W-1:0] w_cnt_ra;
    logic             w_h_issue;
    logic [CNT_W-1:0] r_hidx;
    logic             r_hpv;
    logic [SYM_W-1:0] r_hidx_q;
    logic             w_leaf_we;

    // Node store and merge
    t_node             r_node_mem [NODE_MAX];
    t_node             r_node_q;
    logic              w_nd_we;
    logic [NODE_W-1:0] w_nd_wa;
    t_node             w_nd_wd;
    logic              w_nd_re;
    logic [NODE_W-1:0] w_nd_ra;
    logic [CNT_W-1:0]  r_n;
    logic [NODE_W-1:0] r_next;
    logic [NODE_W-1:0] r_sidx;
    logic              r_spv;
    logic [NODE_W-1:0] r_sidx_q;
    logic              w_s_issue;
    logic              r_a_vld;
    t_weight           r_a_w;
    logic [NODE_W-1:0] r_a_idx;
    logic [SYM_W-1:0]  r_a_sym;
    logic              r_b_vld;
    t_weight           r_b_w;
    logic [NODE_W-1:0] r_b_idx;
    logic [SYM_W-1:0]  r_b_sym;
    logic [COUNT_BITS:0] w_sum_full;
    t_weight           w_sum;

    // Walk
    logic [SYM_W-1:0]  r_leaf;
    logic [NODE_W-1:0] r_cur;
    logic [SYM_W-1:0]  r_depth;
    logic [CODE_W-1:0] r_code;
    logic [SYM_W-1:0]  r_sym;
    logic [SYM_W-1:0]  w_sym;
    logic              r_too_long;
    logic [CW-1:0]     w_n_x;
    logic [CW-1:0]     w_cur_x;
    logic              w_cond;
    logic              w_leaf_done;

    // Code tables
    logic              r_seen [SYMBOLS];
    logic [CODE_W-1:0] r_code_mem [SYMBOLS];
    logic [LEN_W-1:0]  r_len_mem [SYMBOLS];
    logic [CODE_W-1:0] r_code_q;
    logic [LEN_W-1:0]  r_len_q;
    logic              r_hit;

    // Result register
    logic                          r_out_vld;
    logic [CODE_W-1:0]             r_out_bits;
    logic [LEN_W-1:0]              r_out_len;
    logic [hcb_pkg::NSYM_W-1:0]    r_out_nsym;
    logic [hcb_pkg::STATUS_W-1:0]  r_out_status;

    assign w_smp_ok  = int'(r_sample) < SYMBOLS;
    assign w_smp_idx = r_sample[SYM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sample <= i_sample;
        end
    end

    // ---------------- histogram ----------------
    assign w_h_issue = i_cmd.hist && (r_hidx != CNT_W'(SYMBOLS));
    assign w_cnt_re  = i_cmd.cnt_rd || w_h_issue;
    assign w_cnt_ra  = i_cmd.hist ? r_hidx[SYM_W-1:0] : w_smp_idx;
    assign w_cnt_eff = r_cnt_rv ? r_cnt_q : '0;
    assign w_cnt_inc = (&w_cnt_eff) ? w_cnt_eff : w_cnt_eff + COUNT_BITS'(1);
    assign w_leaf_we = i_cmd.hist && r_hpv && (w_cnt_eff != '0);

    always_ff @(posedge i_clk) begin
        if (w_cnt_re) begin
            r_cnt_q  <= r_cnt_mem[w_cnt_ra];
            r_cnt_rv <= r_cnt_vld[w_cnt_ra];
        end
        if (i_cmd.cnt_wr && w_smp_ok) begin
            r_cnt_mem[w_smp_idx] <= w_cnt_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.fin) begin
            for (int i = 0; i < SYMBOLS; i++) begin
                r_cnt_vld[i] <= 1'b0;
            end
        end else if (i_cmd.cnt_wr && w_smp_ok) begin
            r_cnt_vld[w_smp_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hidx <= '0;
            r_hpv  <= 1'b0;
            r_n    <= '0;
            r_next <= '0;
        end else if (i_cmd.load) begin
            r_hidx <= '0;
            r_hpv  <= 1'b0;
            r_n    <= '0;
            r_next <= '0;
        end else begin
            if (i_cmd.hist) begin
                r_hpv <= w_h_issue;
                if (w_h_issue) begin
                    r_hidx <= r_hidx + CNT_W'(1);
                end
            end
            if (w_leaf_we) begin
                r_n    <= r_n + CNT_W'(1);
                r_next <= r_next + NODE_W'(1);
            end
            if (i_cmd.mrg_n) begin
                r_next <= r_next + NODE_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_h_issue) begin
            r_hidx_q <= r_hidx[SYM_W-1:0];
        end
    end

    // ---------------- node store ----------------
    assign w_sum_full = {1'b0, r_a_w} + {1'b0, r_b_w};
    assign w_sum      = w_sum_full[COUNT_BITS] ? '1 : w_sum_full[COUNT_BITS-1:0];

    always_comb begin
        w_nd_we = 1'b0;
        w_nd_wa = r_next;
        w_nd_wd = '0;
        priority if (w_leaf_we) begin
            w_nd_we        = 1'b1;
            w_nd_wa        = NODE_W'(r_n);
            w_nd_wd.weight = w_cnt_eff;
            w_nd_wd.active = 1'b1;
            w_nd_wd.sym    = r_hidx_q;
        end else if (i_cmd.mrg_a) begin
            w_nd_we        = 1'b1;
            w_nd_wa        = r_a_idx;
            w_nd_wd.weight = r_a_w;
            w_nd_wd.parent = r_next;
            w_nd_wd.sym    = r_a_sym;
        end else if (i_cmd.mrg_b) begin
            w_nd_we         = 1'b1;
            w_nd_wa         = r_b_idx;
            w_nd_wd.weight  = r_b_w;
            w_nd_wd.parent  = r_next;
            w_nd_wd.bit_one = 1'b1;
            w_nd_wd.sym     = r_b_sym;
        end else if (i_cmd.mrg_n) begin
            w_nd_we        = 1'b1;
            w_nd_wa        = r_next;
            w_nd_wd.weight = w_sum;
            w_nd_wd.active = 1'b1;
        end else begin
            w_nd_we = 1'b0;
        end
    end

    assign w_s_issue = i_cmd.scan && (r_sidx != r_next);

    always_comb begin
        w_nd_re = 1'b0;
        w_nd_ra = r_sidx;
        priority if (w_s_issue) begin
            w_nd_re = 1'b1;
        end else if (i_cmd.leaf_rd) begin
            w_nd_re = 1'b1;
            w_nd_ra = NODE_W'(r_leaf);
        end else if (i_cmd.step && w_cond) begin
            w_nd_re = 1'b1;
            w_nd_ra = r_node_q.parent;
        end else begin
            w_nd_re = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_nd_we) begin
            r_node_mem[w_nd_wa] <= w_nd_wd;
        end
        if (w_nd_re) begin
            r_node_q <= r_node_mem[w_nd_ra];
        end
    end

    // Scan over all nodes made so far, keeping the two smallest active ones.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.scan_init) begin
            r_sidx  <= '0;
            r_spv   <= 1'b0;
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else if (i_cmd.scan) begin
            r_spv <= w_s_issue;
            if (w_s_issue) begin
                r_sidx <= r_sidx + NODE_W'(1);
            end
            if (r_spv && r_node_q.active) begin
                if (!r_a_vld || f_less(r_node_q.weight, r_sidx_q, r_a_w, r_a_idx,
                                       NODE_W'(r_n))) begin
                    r_b_vld <= r_a_vld;
                    r_a_vld <= 1'b1;
                end else if (!r_b_vld || f_less(r_node_q.weight, r_sidx_q, r_b_w,
                                                r_b_idx, NODE_W'(r_n))) begin
                    r_b_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_issue) begin
            r_sidx_q <= r_sidx;
        end
        if (i_cmd.scan && r_spv && r_node_q.active) begin
            if (!r_a_vld || f_less(r_node_q.weight, r_sidx_q, r_a_w, r_a_idx,
                                   NODE_W'(r_n))) begin
                r_b_w   <= r_a_w;
                r_b_idx <= r_a_idx;
                r_b_sym <= r_a_sym;
                r_a_w   <= r_node_q.weight;
                r_a_idx <= r_sidx_q;
                r_a_sym <= r_node_q.sym;
            end else if (!r_b_vld || f_less(r_node_q.weight, r_sidx_q, r_b_w,
                                            r_b_idx, NODE_W'(r_n))) begin
                r_b_w   <= r_node_q.weight;
                r_b_idx <= r_sidx_q;
                r_b_sym <= r_node_q.sym;
            end
        end
    end

    // ---------------- walk from each leaf to the root ----------------
    assign w_n_x   = CW'(r_n);
    assign w_cur_x = CW'(r_cur);
    assign w_cond  = (w_cur_x < w_n_x) ? (w_n_x > CW'(1))
                                       : (w_cur_x < ((w_n_x << 1) - CW'(2)));
    assign w_sym       = (r_depth == '0) ? r_node_q.sym : r_sym;
    assign w_leaf_done = i_cmd.step && !w_cond;

    always_ff @(posedge i_clk) begin
        if (i_cmd.leaf_rd) begin
            r_cur   <= NODE_W'(r_leaf);
            r_depth <= '0;
            r_code  <= '0;
        end else if (i_cmd.step && w_cond) begin
            r_code  <= r_code | (CODE_W'(r_node_q.bit_one) << r_depth);
            r_depth <= r_depth + SYM_W'(1);
            r_cur   <= r_node_q.parent;
            if (r_depth == '0) begin
                r_sym <= r_node_q.sym;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.load) begin
            r_leaf     <= '0;
            r_too_long <= 1'b0;
        end else if (w_leaf_done) begin
            r_leaf <= r_leaf + SYM_W'(1);
            if (int'(r_depth) > MAX_CODE_LEN) begin
                r_too_long <= 1'b1;
            end
        end
    end

    // ---------------- code tables ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.hist || (i_cmd.fin && r_too_long)) begin
            for (int i = 0; i < SYMBOLS; i++) begin
                r_seen[i] <= 1'b0;
            end
        end else if (w_leaf_done) begin
            r_seen[w_sym] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_leaf_done) begin
            r_code_mem[w_sym] <= r_code;
            r_len_mem[w_sym]  <= LEN_W'(r_depth);
        end
        if (i_cmd.enc_rd) begin
            r_code_q <= r_code_mem[w_smp_idx];
            r_len_q  <= r_len_mem[w_smp_idx];
            r_hit    <= w_smp_ok && r_seen[w_smp_idx];
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.enc_out || i_cmd.fin) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.enc_out) begin
            r_out_bits   <= r_hit ? r_code_q : '0;
            r_out_len    <= r_hit ? r_len_q : '0;
            r_out_nsym   <= '0;
            r_out_status <= r_hit ? hcb_pkg::ST_OK : hcb_pkg::ST_UNSEEN;
        end else if (i_cmd.fin) begin
            r_out_bits <= '0;
            r_out_len  <= '0;
            r_out_nsym <= hcb_pkg::NSYM_W'(r_n);
            if (r_n == '0) begin
                r_out_status <= hcb_pkg::ST_EMPTY;
            end else if (r_too_long) begin
                r_out_status <= hcb_pkg::ST_LONG;
            end else begin
                r_out_status <= hcb_pkg::ST_OK;
            end
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_code_bits    = r_out_bits;
    assign o_code_length  = r_out_len;
    assign o_symbol_count = r_out_nsym;
    assign o_status       = r_out_status;

    assign o_stat.hist_done   = (r_hidx == CNT_W'(SYMBOLS)) && !r_hpv;
    assign o_stat.n_zero      = (r_n == '0);
    assign o_stat.scan_done   = (r_sidx == r_next) && !r_spv;
    assign o_stat.merges_done = CW'(r_next) == ((w_n_x << 1) - CW'(1));
    assign o_stat.step_cond   = w_cond;
    assign o_stat.leaf_last   = CW'(r_leaf) == (w_n_x - CW'(1));
    assign o_stat.out_free    = !r_out_vld || i_out_ready;

endmodule
